// ===== sv/sta_pkg.sv =====
package sta_pkg;

    localparam int SLOTS_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    // slots examined per cycle by the free-slot search
    localparam int GROUP_SLOTS = 16;
    localparam int GROUP_IDX_W = 4;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_EDIT   = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot_index;
        logic [31:0] item_value;
    } sta_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_index;
        logic [31:0] read_value;
        logic [4:0]  used_count;
    } sta_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } sta_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } sta_cmd_t;

    typedef struct packed {
        logic exec_done;
        logic out_free;
    } sta_sts_t;

endpackage

// ===== sv/slot_table_allocator_top.sv =====
// Slot table with lowest-free-slot allocation.
//
// Input channel s_valid/s_ready/s_data carries one command transaction:
// func, slot_index and item_value. Output channel m_valid/m_ready/m_data
// returns exactly one result transaction per command: status, result_index,
// read_value and the count of used slots after the command.
//
// Commands are handled one at a time: accepted in S_IDLE, executed in S_EXEC and
// moved into the output register in S_FINISH. Add may stay in S_EXEC while the
// free-slot search walks the groups, since it looks at sixteen valid bits per
// cycle. Edit, delete, read, clear and unknown codes need no search. The next
// command is taken only after the previous result has been moved into the output
// register, so a new command is never accepted while one is still executing.
//
// Reset (aresetn low, synchronous) empties the table at once and drops any
// pending result. Stored words are not cleared; they are only ever read
// through a valid slot. If the receiver holds m_ready low the result stays
// on m_data, one further command may be accepted and executed, and its
// result waits in the datapath until the output register frees up.
module slot_table_allocator_top #(
    parameter int SLOTS     = sta_pkg::SLOTS_DEFAULT,
    parameter int WORD_BITS = sta_pkg::WORD_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sta_pkg::sta_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sta_pkg::sta_out_t m_data
);

    sta_pkg::sta_cmd_t cmd;
    sta_pkg::sta_sts_t sts;

    sta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sta_datapath #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while another was executing");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.used_count) <= SLOTS))
        else $error("used count beyond table size");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == sta_pkg::ST_FULL) |-> (m_data.used_count == 5'(SLOTS)))
        else $error("table reported full with free slots");

    a_read_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != sta_pkg::ST_OK) |-> (m_data.read_value == 32'd0))
        else $error("read value returned on a failed command");

endmodule

// ===== sv/sta_ctrl.sv =====
module sta_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sta_pkg::sta_sts_t sts,
    output sta_pkg::sta_cmd_t cmd
);

    sta_pkg::sta_state_t state_reg;
    sta_pkg::sta_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sta_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sta_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = sta_pkg::S_EXEC;
                end
            end
            sta_pkg::S_EXEC: begin
                if (sts.exec_done) begin
                    state_next = sta_pkg::S_FINISH;
                end
            end
            sta_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    state_next = sta_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sta_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            sta_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            sta_pkg::S_EXEC: begin
                cmd.execute = 1'b1;
            end
            sta_pkg::S_FINISH: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/sta_datapath.sv =====
module sta_datapath #(
    parameter int SLOTS     = sta_pkg::SLOTS_DEFAULT,
    parameter int WORD_BITS = sta_pkg::WORD_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sta_pkg::sta_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sta_pkg::sta_out_t m_data,
    input  sta_pkg::sta_cmd_t cmd,
    output sta_pkg::sta_sts_t sts
);

    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int NUM_GROUPS = (SLOTS + sta_pkg::GROUP_SLOTS - 1) / sta_pkg::GROUP_SLOTS;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_SLOTS  = NUM_GROUPS * sta_pkg::GROUP_SLOTS;

    // captured transaction
    logic [2:0]           func_reg;
    logic [3:0]           idx_reg;
    logic [WORD_BITS-1:0] value_reg;

    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     valid_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [GRP_W-1:0]     grp_reg;
    logic [GRP_W-1:0]     grp_next;

    logic [WORD_BITS-1:0] slot_mem [SLOTS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // staged result, waiting for the output register
    logic [1:0]           st_status_reg;
    logic [1:0]           st_status_next;
    logic [3:0]           st_index_reg;
    logic [3:0]           st_index_next;
    logic                 st_use_rd_reg;
    logic                 st_use_rd_next;

    logic                 m_valid_reg;
    sta_pkg::sta_out_t    m_data_reg;

    logic [PAD_SLOTS-1:0]              valid_pad;
    logic [sta_pkg::GROUP_SLOTS-1:0]   grp_bits;
    logic [sta_pkg::GROUP_IDX_W-1:0]   free_enc;
    logic                              free_any;
    logic                              last_grp;
    logic [SLOT_W-1:0]                 free_addr;
    logic [SLOT_W-1:0]                 idx_addr;
    logic                              hit;
    logic                              wr_en;
    logic [SLOT_W-1:0]                 wr_addr;
    logic                              rd_en;

    // slots past the end of the table count as used
    always_comb begin
        valid_pad = '1;
        for (int i = 0; i < SLOTS; i++) begin
            valid_pad[i] = valid_reg[i];
        end
    end

    assign grp_bits = valid_pad[grp_reg * sta_pkg::GROUP_SLOTS +: sta_pkg::GROUP_SLOTS];

    // lowest free slot of the current group
    always_comb begin
        free_enc = '0;
        free_any = 1'b0;
        for (int i = sta_pkg::GROUP_SLOTS - 1; i >= 0; i--) begin
            if (!grp_bits[i]) begin
                free_enc = sta_pkg::GROUP_IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign last_grp  = (grp_reg == GRP_W'(NUM_GROUPS - 1));
    assign free_addr = SLOT_W'({grp_reg, free_enc});
    assign idx_addr  = SLOT_W'(idx_reg);
    assign hit       = (int'(idx_reg) < SLOTS) && valid_reg[idx_addr];

    always_comb begin
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        grp_next       = grp_reg;
        st_status_next = st_status_reg;
        st_index_next  = st_index_reg;
        st_use_rd_next = st_use_rd_reg;
        wr_en          = 1'b0;
        wr_addr        = free_addr;
        rd_en          = 1'b0;
        sts.exec_done  = 1'b1;
        sts.out_free   = !m_valid_reg || m_ready;
        if (cmd.capture) begin
            grp_next = '0;
        end
        if (cmd.execute) begin
            st_status_next = sta_pkg::ST_OK;
            st_index_next  = '0;
            st_use_rd_next = 1'b0;
            case (func_reg)
                sta_pkg::OP_ADD: begin
                    if (free_any) begin
                        valid_next[free_addr] = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                        wr_en         = 1'b1;
                        st_index_next = free_enc;
                    end else if (last_grp) begin
                        st_status_next = sta_pkg::ST_FULL;
                    end else begin
                        // advance to the next group and search again
                        grp_next      = grp_reg + 1'b1;
                        sts.exec_done = 1'b0;
                    end
                end
                sta_pkg::OP_EDIT: begin
                    if (hit) begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_addr;
                        st_index_next = idx_reg;
                    end else begin
                        st_status_next = sta_pkg::ST_ABSENT;
                    end
                end
                sta_pkg::OP_DELETE: begin
                    if (hit) begin
                        valid_next[idx_addr] = 1'b0;
                        cnt_next      = cnt_reg - 1'b1;
                        st_index_next = idx_reg;
                    end else begin
                        st_status_next = sta_pkg::ST_ABSENT;
                    end
                end
                sta_pkg::OP_READ: begin
                    if (hit) begin
                        rd_en          = 1'b1;
                        st_use_rd_next = 1'b1;
                        st_index_next  = idx_reg;
                    end else begin
                        st_status_next = sta_pkg::ST_ABSENT;
                    end
                end
                sta_pkg::OP_CLEAR: begin
                    valid_next = '0;
                    cnt_next   = '0;
                end
                default: begin
                    st_status_next = sta_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            cnt_reg     <= '0;
            grp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_data.func;
            idx_reg   <= s_data.slot_index;
            value_reg <= WORD_BITS'(s_data.item_value);
        end
        st_status_reg <= st_status_next;
        st_index_reg  <= st_index_next;
        st_use_rd_reg <= st_use_rd_next;
        if (cmd.load_out) begin
            m_data_reg.status       <= st_status_reg;
            m_data_reg.result_index <= st_index_reg;
            m_data_reg.read_value   <= st_use_rd_reg ? 32'(rd_data_reg) : 32'd0;
            m_data_reg.used_count   <= 5'(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= value_reg;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[idx_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

// ===== bench/slot_table_allocator_top_test.sv =====
// Mirror of the slot table: predicts each result and checks the DUT against it
class slot_table_mirror;
    localparam int TABLE_SLOTS = sta_pkg::SLOTS_DEFAULT;

    bit        slot_used [TABLE_SLOTS];
    bit [31:0] slot_word [TABLE_SLOTS];
    bit [4:0]  used_total;
    sta_pkg::sta_out_t awaited [$];
    int unsigned failures;

    function new();
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_word[i] = '0;
        end
        used_total = '0;
        failures   = 0;
    endfunction

    function void note_command(sta_pkg::sta_in_t cmd);
        sta_pkg::sta_out_t res;
        res = '0;
        res.status = sta_pkg::ST_OK;
        case (cmd.func)
            sta_pkg::OP_ADD: begin
                res.status = sta_pkg::ST_FULL;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_word[i] = cmd.item_value;
                        used_total++;
                        res.status = sta_pkg::ST_OK;
                        res.result_index = i[3:0];
                        break;
                    end
                end
            end
            sta_pkg::OP_EDIT, sta_pkg::OP_DELETE, sta_pkg::OP_READ: begin
                if (!slot_used[cmd.slot_index]) begin
                    res.status = sta_pkg::ST_ABSENT;
                end else begin
                    res.result_index = cmd.slot_index;
                    if (cmd.func == sta_pkg::OP_EDIT) begin
                        slot_word[cmd.slot_index] = cmd.item_value;
                    end else if (cmd.func == sta_pkg::OP_DELETE) begin
                        slot_used[cmd.slot_index] = 1'b0;
                        used_total--;
                    end else begin
                        res.read_value = slot_word[cmd.slot_index];
                    end
                end
            end
            sta_pkg::OP_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
                used_total = '0;
            end
            default: ;
        endcase
        res.used_count = used_total;
        awaited.push_back(res);
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
        failures++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(sta_pkg::sta_out_t got);
        sta_pkg::sta_out_t want;
        if (awaited.size() == 0) begin
            flag_field("unexpected result", '0, got.read_value);
            return;
        end
        want = awaited.pop_front();
        if (got.status !== want.status)
            flag_field("status", 32'(want.status), 32'(got.status));
        if (got.result_index !== want.result_index)
            flag_field("result_index", 32'(want.result_index), 32'(got.result_index));
        if (got.read_value !== want.read_value)
            flag_field("read_value", want.read_value, got.read_value);
        if (got.used_count !== want.used_count)
            flag_field("used_count", 32'(want.used_count), 32'(got.used_count));
    endfunction

    // bias edit, delete and read towards slots that are in use
    function bit [3:0] pick_slot();
        int unsigned live [$];
        foreach (slot_used[i]) if (slot_used[i]) live.push_back(i);
        if (live.size() == 0 || $urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, TABLE_SLOTS - 1));
        return 4'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
endclass

module slot_table_allocator_top_test;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_FROM    = 1150;
    localparam int STUCK_LIMIT  = 2000;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sta_pkg::sta_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sta_pkg::sta_out_t m_data;

    bit quiet = 1'b0;
    int unsigned stuck_cycles = 0;
    slot_table_mirror mirror;

    slot_table_allocator_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic sta_pkg::sta_in_t make_cmd(logic [2:0] func, logic [3:0] idx,
                                                  logic [31:0] value);
        sta_pkg::sta_in_t cmd;
        cmd.func       = func;
        cmd.slot_index = idx;
        cmd.item_value = value;
        return cmd;
    endfunction

    function automatic sta_pkg::sta_in_t random_cmd(bit filling);
        int unsigned roll;
        logic [2:0]  func;
        logic [31:0] value;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 50 : 25))      func = sta_pkg::OP_ADD;
        else if (roll < (filling ? 62 : 37)) func = sta_pkg::OP_EDIT;
        else if (roll < (filling ? 74 : 67)) func = sta_pkg::OP_DELETE;
        else if (roll < 92)                  func = sta_pkg::OP_READ;
        else if (roll < 94)                  func = sta_pkg::OP_CLEAR;
        else                                 func = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        value = $urandom;
        if ($urandom_range(0, 9) == 0)
            value = $urandom_range(0, 1) ? '1 : '0;
        return make_cmd(func, mirror.pick_slot(), value);
    endfunction

    task automatic send_command(sta_pkg::sta_in_t cmd);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        mirror.note_command(cmd);
    endtask

    task automatic sender_pause(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // hold the sender off until the table has answered everything
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (mirror.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic directed_sequence();
        logic [31:0] value;
        send_command(make_cmd(sta_pkg::OP_READ,   4'd0,  '0));
        send_command(make_cmd(sta_pkg::OP_EDIT,   4'd15, '1));
        send_command(make_cmd(sta_pkg::OP_DELETE, 4'd7,  '0));
        for (int k = 0; k < sta_pkg::SLOTS_DEFAULT; k++) begin
            value = (k == 0) ? '0 : (k == 1) ? '1 : $urandom;
            send_command(make_cmd(sta_pkg::OP_ADD, k[3:0], value));
        end
        send_command(make_cmd(sta_pkg::OP_ADD,    4'd0,  32'h5a5a_a5a5));
        send_command(make_cmd(sta_pkg::OP_EDIT,   4'd15, '1));
        send_command(make_cmd(sta_pkg::OP_READ,   4'd15, '0));
        send_command(make_cmd(sta_pkg::OP_DELETE, 4'd0,  '0));
        send_command(make_cmd(sta_pkg::OP_ADD,    4'd9,  32'h1234_5678));
        send_command(make_cmd(OP_SPARE_LO, 4'd3, '1));
        send_command(make_cmd(OP_SPARE_HI, 4'd12, '0));
        send_command(make_cmd(sta_pkg::OP_CLEAR,  4'd5,  '1));
        send_command(make_cmd(sta_pkg::OP_READ,   4'd3,  '0));
    endtask

    // receiver stalls in short bursts
    always @(negedge aclk) begin
        static int stall_left = 0;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        bit filling;
        mirror  = new();
        filling = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        directed_sequence();
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= CALM_FROM) || ((n / 100) % 5 == 4);
            if (n % 64 == 0)
                filling = !filling;
            if (n == 400 || n == 800)
                drain_results();
            if (!quiet && $urandom_range(0, 4) == 0)
                sender_pause($urandom_range(1, 3));
            send_command(random_cmd(filling));
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mirror.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
